/* rtl/kpvt_pkg.sv */
// shared types, constants and fixed-point helpers of the kalman tracker
package kpvt_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int CFG_W         = 31;
    localparam int VAL_W         = 32;
    localparam int IDX_W         = 2;

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_TIME_STEP  = 2'd0;
    localparam logic [IDX_W-1:0] REG_POS_NOISE  = 2'd1;
    localparam logic [IDX_W-1:0] REG_VEL_NOISE  = 2'd2;
    localparam logic [IDX_W-1:0] REG_MEAS_NOISE = 2'd3;

    // datapath operations, one per sequencer step
    typedef enum logic [4:0] {
        OP_NONE,
        OP_PRED_POS,   // pos += mul(vel,dt)
        OP_DTDT,       // t0 = mul(dt,dt)
        OP_P00_A,      // acc = P00 + q_pos + mul(dt, sat(P10+P01))
        OP_P00_B,      // p00 = sat(acc + mul(t0,P11))
        OP_P01,        // p01 = sat(P01 + mul(dt,P11)), p10 likewise
        OP_P11,        // p11 = sat(P11 + q_vel), S, skip test
        OP_DIV0_START, // start K0 = p00/S
        OP_DIV0_END,
        OP_DIV1_START, // start K1 = p10/S
        OP_DIV1_END,
        OP_CORR_INIT,  // y, c, n
        OP_POS_CORR,
        OP_VEL_CORR,
        OP_C_P00,
        OP_C_P01,
        OP_N_P00,
        OP_N_P01
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN,
        ST_DIV,
        ST_OUT
    } t_state;

    typedef struct packed {
        t_op  op;
        logic load_meas;
    } t_cmd;

    typedef struct packed {
        logic div_busy;
        logic skip;
    } t_status;

    function automatic logic signed [VAL_W-1:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647)       return 32'sh7fffffff;
        else if (v < -66'sd2147483648) return 32'sh80000000;
        else                            return v[VAL_W-1:0];
    endfunction

endpackage

/* rtl/kpvt_div.sv */
// radix-2 restoring divider: (num << FRAC_BITS) / den, truncated, saturated
module kpvt_div import kpvt_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [VAL_W-1:0] i_num,
    input  logic [VAL_W:0]          i_den,   // positive, up to 33 bits
    output logic                    o_busy,
    output logic signed [VAL_W-1:0] o_quot
);
    localparam int NW = VAL_W + FRAC_BITS;   // dividend magnitude width
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0]   r_dvd, n_dvd;
    logic [NW-1:0]   r_q, n_q;
    logic [VAL_W+1:0] r_rem, n_rem;
    logic [VAL_W:0]  r_den;
    logic            r_neg;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic            r_busy;
    logic [VAL_W+1:0] w_trial;
    logic [NW:0]     w_qs;

    // one quotient bit per cycle
    always_comb begin
        w_trial = {r_rem[VAL_W:0], r_dvd[NW-1]};
        n_dvd   = {r_dvd[NW-2:0], 1'b0};
        if (w_trial >= {1'b0, r_den}) begin
            n_rem = w_trial - {1'b0, r_den};
            n_q   = {r_q[NW-2:0], 1'b1};
        end else begin
            n_rem = w_trial;
            n_q   = {r_q[NW-2:0], 1'b0};
        end
        n_cnt = r_cnt - CW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(NW);
        end else if (r_busy) begin
            r_cnt <= n_cnt;
            if (n_cnt == '0) r_busy <= 1'b0;
        end
    end

    // operands and partial results
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_num[VAL_W-1];
            r_dvd <= {(i_num[VAL_W-1] ? (~i_num[VAL_W-1:0] + 1'b1) : i_num[VAL_W-1:0]),
                      {FRAC_BITS{1'b0}}};
            r_den <= i_den;
            r_rem <= '0;
            r_q   <= '0;
        end else if (r_busy) begin
            r_dvd <= n_dvd;
            r_rem <= n_rem;
            r_q   <= n_q;
        end
    end

    // sign and saturation of the quotient
    always_comb begin
        w_qs = r_neg ? ((NW+1)'(0) - {1'b0, r_q}) : {1'b0, r_q};
        if (!r_neg && r_q > NW'(32'h7fffffff))      o_quot = 32'sh7fffffff;
        else if (r_neg && r_q > NW'(33'h80000000))  o_quot = 32'sh80000000;
        else                                         o_quot = w_qs[VAL_W-1:0];
    end

    assign o_busy = r_busy;
endmodule

/* rtl/kpvt_datapath.sv */
// filter state, shared multiplier and step operations
module kpvt_datapath import kpvt_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cmd                    i_cmd,
    input  logic signed [VAL_W-1:0] i_meas,
    input  logic [CFG_W-1:0]        i_dt,
    input  logic [CFG_W-1:0]        i_qpos,
    input  logic [CFG_W-1:0]        i_qvel,
    input  logic [CFG_W-1:0]        i_rnoise,
    output t_status                 o_status,
    output logic signed [VAL_W-1:0] o_pos,
    output logic signed [VAL_W-1:0] o_vel
);
    localparam logic signed [65:0] ONE = 66'sd1 <<< FRAC_BITS;

    logic signed [VAL_W-1:0] r_pos, r_vel, r_pp, r_pv, r_vp, r_vv;
    logic signed [VAL_W-1:0] r_meas, r_t0, r_k0, r_c, r_n, r_y;
    logic signed [65:0]      r_acc;
    logic [VAL_W:0]          r_s;
    logic                    r_skip;
    logic signed [VAL_W-1:0] w_ma, w_mb, w_mul;
    logic signed [63:0]      w_prod;
    logic signed [VAL_W-1:0] w_dt;
    logic signed [65:0]      w_s;
    logic                    w_dstart;
    logic signed [VAL_W-1:0] w_dnum, w_quot;
    logic                    w_busy;

    assign w_dt = {1'b0, i_dt};

    // operand selection for the single multiplier
    always_comb begin
        w_ma = w_dt;
        w_mb = w_dt;
        unique case (i_cmd.op)
            OP_PRED_POS: begin w_ma = r_vel; w_mb = w_dt; end
            OP_P00_A:    begin w_ma = w_dt;  w_mb = sat32(66'(r_vp) + 66'(r_pv)); end
            OP_P00_B:    begin w_ma = r_t0;  w_mb = r_vv; end
            OP_P01:      begin w_ma = w_dt;  w_mb = r_vv; end
            OP_POS_CORR: begin w_ma = r_k0;  w_mb = r_y; end
            OP_VEL_CORR: begin w_ma = w_quot; w_mb = r_y; end
            OP_C_P00:    begin w_ma = r_c;   w_mb = r_pp; end
            OP_C_P01:    begin w_ma = r_c;   w_mb = r_pv; end
            OP_N_P00:    begin w_ma = r_n;   w_mb = r_t0; end
            OP_N_P01:    begin w_ma = r_n;   w_mb = r_acc[VAL_W-1:0]; end
            default:     begin w_ma = w_dt;  w_mb = w_dt; end
        endcase
    end

    // floor shift keeps rounding toward minus infinity
    assign w_prod = 64'(w_ma) * 64'(w_mb);
    assign w_mul  = sat32(66'(w_prod >>> FRAC_BITS));
    assign w_s    = 66'(r_pp) + 66'({1'b0, i_rnoise});

    assign w_dstart = (i_cmd.op == OP_DIV0_START) || (i_cmd.op == OP_DIV1_START);
    assign w_dnum   = (i_cmd.op == OP_DIV0_START) ? r_pp : r_vp;

    kpvt_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_dstart),
        .i_num   (w_dnum),
        .i_den   (r_s),
        .o_busy  (w_busy),
        .o_quot  (w_quot)
    );

    // state updates, one operation per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_vel  <= '0;
            r_pp   <= sat32(66'd1000 * ONE);
            r_pv   <= '0;
            r_vp   <= '0;
            r_vv   <= sat32(66'd1000 * ONE);
            r_skip <= 1'b0;
        end else begin
            if (i_cmd.load_meas) r_meas <= i_meas;
            unique case (i_cmd.op)
                OP_PRED_POS: r_pos <= sat32(66'(r_pos) + 66'(w_mul));
                OP_DTDT:     r_t0  <= w_mul;
                OP_P00_A:    r_acc <= 66'(r_pp) + 66'({1'b0, i_qpos}) + 66'(w_mul);
                OP_P00_B:    r_pp  <= sat32(r_acc + 66'(w_mul));
                OP_P01: begin
                    r_pv <= sat32(66'(r_pv) + 66'(w_mul));
                    r_vp <= sat32(66'(r_vp) + 66'(w_mul));
                end
                OP_P11: begin
                    r_vv   <= sat32(66'(r_vv) + 66'({1'b0, i_qvel}));
                    r_s    <= w_s[VAL_W:0];
                    r_skip <= (w_s <= 0);
                end
                OP_DIV0_END: r_k0 <= w_quot;
                OP_CORR_INIT: begin
                    r_y <= sat32(66'(r_meas) - 66'(r_pos));
                    r_c <= sat32(ONE - 66'(r_k0));
                    r_n <= sat32(66'sd0 - 66'(w_quot));
                    // keep predicted P00/P01 for the covariance update
                    r_t0  <= r_pp;
                    r_acc <= 66'(r_pv);
                end
                OP_POS_CORR: r_pos <= sat32(66'(r_pos) + 66'(w_mul));
                OP_VEL_CORR: r_vel <= sat32(66'(r_vel) + 66'(w_mul));
                OP_C_P00:    r_pp  <= w_mul;
                OP_C_P01:    r_pv  <= w_mul;
                OP_N_P00:    r_vp  <= sat32(66'(w_mul) + 66'(r_vp));
                OP_N_P01:    r_vv  <= sat32(66'(w_mul) + 66'(r_vv));
                default: ;
            endcase
        end
    end

    assign o_status = '{div_busy: w_busy, skip: r_skip};
    assign o_pos    = r_pos;
    assign o_vel    = r_vel;
endmodule

/* rtl/kpvt_ctrl.sv */
// sequencer for one filter step
module kpvt_ctrl import kpvt_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);
    t_state r_state, n_state;
    t_op    r_op, n_op;
    t_op    w_next_op;

    // next operation in program order
    always_comb begin
        unique case (r_op)
            OP_PRED_POS:   w_next_op = OP_DTDT;
            OP_DTDT:       w_next_op = OP_P00_A;
            OP_P00_A:      w_next_op = OP_P00_B;
            OP_P00_B:      w_next_op = OP_P01;
            OP_P01:        w_next_op = OP_P11;
            OP_P11:        w_next_op = OP_DIV0_START;
            OP_DIV0_START: w_next_op = OP_DIV0_END;
            OP_DIV0_END:   w_next_op = OP_DIV1_START;
            OP_DIV1_START: w_next_op = OP_DIV1_END;
            OP_DIV1_END:   w_next_op = OP_CORR_INIT;
            OP_CORR_INIT:  w_next_op = OP_POS_CORR;
            OP_POS_CORR:   w_next_op = OP_VEL_CORR;
            OP_VEL_CORR:   w_next_op = OP_C_P00;
            OP_C_P00:      w_next_op = OP_C_P01;
            OP_C_P01:      w_next_op = OP_N_P00;
            OP_N_P00:      w_next_op = OP_N_P01;
            default:       w_next_op = OP_NONE;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        unique case (r_state)
            ST_IDLE: if (i_in_valid) begin
                n_state = ST_RUN;
                n_op    = OP_PRED_POS;
            end
            ST_RUN: begin
                if (r_op == OP_P11) begin
                    n_op = OP_DIV0_START;
                end else if (r_op == OP_DIV0_START || r_op == OP_DIV1_START) begin
                    n_state = ST_DIV;
                    n_op    = OP_NONE;
                end else if (r_op == OP_DIV1_END) begin
                    n_op = OP_CORR_INIT;
                end else if (w_next_op == OP_NONE) begin
                    n_state = ST_OUT;
                    n_op    = OP_NONE;
                end else begin
                    n_op = w_next_op;
                end
                // skip test result is registered at OP_P11
                if (r_op == OP_DIV0_START && i_status.skip) begin
                    n_state = ST_OUT;
                    n_op    = OP_NONE;
                end
            end
            ST_DIV: if (!i_status.div_busy) begin
                n_state = ST_RUN;
                n_op    = (r_op == OP_NONE) ? OP_DIV0_END : OP_DIV1_END;
            end
            ST_OUT: if (i_out_ready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs: gate the division start when the correction is skipped
    always_comb begin
        o_in_ready    = (r_state == ST_IDLE);
        o_out_valid   = (r_state == ST_OUT);
        o_cmd.load_meas = (r_state == ST_IDLE) && i_in_valid;
        o_cmd.op      = OP_NONE;
        if (r_state == ST_RUN) begin
            if (r_op == OP_DIV0_START && i_status.skip) o_cmd.op = OP_NONE;
            else                                         o_cmd.op = r_op;
        end
    end

    // remembers which division is in flight
    logic r_second;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_op     <= OP_NONE;
            r_second <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_RUN && r_op == OP_DIV0_START) r_second <= 1'b0;
            if (r_state == ST_RUN && r_op == OP_DIV1_START) r_second <= 1'b1;
            if (r_state == ST_DIV && !i_status.div_busy)
                r_op <= r_second ? OP_DIV1_END : OP_DIV0_END;
            else
                r_op <= n_op;
        end
    end
endmodule

/* rtl/kalman_pos_vel_tracker.sv */
// top level of the two-state constant-velocity kalman tracker
//  channel | signals                                   | direction
//  in      | i_in_valid, o_in_ready, i_measured_pos    | sample in
//  out     | o_out_valid, i_out_ready, o_est_*, o_corr | estimate out
//  cfg     | i_cfg_we, i_cfg_idx, i_cfg_data           | register write
// a step from one accepted sample to the next is dominated by the two bit-serial
// divisions, which share one divider and each hold the sequencer until done;
// a skipped correction ends the step before the first division starts
// reset is synchronous and restores the state and registers to their defaults
// one transaction is in work at a time; a stalled result holds the block
module kalman_pos_vel_tracker import kpvt_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic signed [VAL_W-1:0] i_measured_pos,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic signed [VAL_W-1:0] o_est_position,
    output logic signed [VAL_W-1:0] o_est_velocity,
    output logic                    o_correction_skipped,
    input  logic                    i_cfg_we,
    input  logic [IDX_W-1:0]        i_cfg_idx,
    input  logic [CFG_W-1:0]        i_cfg_data
);
    logic [CFG_W-1:0] r_dt, r_qpos, r_qvel, r_rn;
    t_cmd    w_cmd;
    t_status w_status;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dt   <= CFG_W'(1) << FRAC_BITS;
            r_qpos <= '0;
            r_qvel <= '0;
            r_rn   <= CFG_W'(1) << FRAC_BITS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_TIME_STEP:  r_dt   <= i_cfg_data;
                REG_POS_NOISE:  r_qpos <= i_cfg_data;
                REG_VEL_NOISE:  r_qvel <= i_cfg_data;
                REG_MEAS_NOISE: r_rn   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    kpvt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    kpvt_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_meas   (i_measured_pos),
        .i_dt     (r_dt),
        .i_qpos   (r_qpos),
        .i_qvel   (r_qvel),
        .i_rnoise (r_rn),
        .o_status (w_status),
        .o_pos    (o_est_position),
        .o_vel    (o_est_velocity)
    );

    assign o_correction_skipped = w_status.skip;
endmodule
